// ----- rtl/core/tdsm_pkg.sv -----
// tdsm_pkg: shared widths, constants and types for the tank drive stick mixer
// used by tdsm_divider and tank_drive_stick_mixer_unit
package tdsm_pkg;

  localparam int unsigned GEAR_COUNT = 4;
  localparam int unsigned GEAR_W     = 3;
  localparam int unsigned STICK_W    = 8;
  localparam int unsigned BAND_W     = 7;
  localparam int unsigned LAMP_W     = 7;
  localparam int unsigned NUM_W      = 18;
  localparam int unsigned DEN_W      = 11;
  localparam int unsigned CNT_W      = $clog2(NUM_W + 1);

  localparam int unsigned IN_W  = 56;
  localparam int unsigned OUT_W = 64;

  localparam logic [BAND_W-1:0]  DEAD_BAND_RST = BAND_W'(10);
  localparam logic [BAND_W-1:0]  BAND_FULL     = BAND_W'(127);
  localparam logic [LAMP_W-1:0]  LAMP_ON       = LAMP_W'(100);
  localparam logic [GEAR_W-1:0]  GEAR_TOP      = GEAR_W'(GEAR_COUNT);
  localparam logic [GEAR_W-1:0]  GEAR_LOW      = GEAR_W'(1);

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/core/tdsm_divider.sv -----
// tdsm_divider: shared restoring unsigned divider, one quotient bit per cycle
// depends on tdsm_pkg
module tdsm_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tdsm_pkg::div_req_t  req_i,
  output tdsm_pkg::div_rsp_t  rsp_o
);
  import tdsm_pkg::*;

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             fits;

  always_comb begin
    trial  = {rem_q, quo_q[NUM_W-1]};
    fits   = trial >= {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

// ----- rtl/core/tank_drive_stick_mixer_unit.sv -----
// tank_drive_stick_mixer_unit: top level, frame sequencer, gear and lamp state
// depends on tdsm_pkg and tdsm_divider
//
// One control frame runs eight divisions (six stick deadzone rescales, then right
// and left track), each through the single shared 18-step divider with a load
// state before it and a capture of the quotient when it is done, followed by a
// post state that writes the result. s_axis_tready is high only between frames.
// A finished result sits in the output register while the next frame is accepted.
// The user writes dead_band through cfg_we_i while the block is idle; it is not enforced.
module tank_drive_stick_mixer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tdsm_pkg::BAND_W-1:0] cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // steer, throttle, turret, pitch, extend, winch (8 each),
  // gear down, gear up, lamp button (1 each), zero pad
  input  logic [tdsm_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // right track, left track, turret, pitch, extend, winch (8 each),
  // lamp level (7), gear now (3), zero pad
  output logic [tdsm_pkg::OUT_W-1:0]  m_axis_tdata
);
  import tdsm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WAIT,
    ST_POST
  } state_e;

  localparam logic [2:0] OP_STEER    = 3'd0;
  localparam logic [2:0] OP_THROTTLE = 3'd1;
  localparam logic [2:0] OP_TURRET   = 3'd2;
  localparam logic [2:0] OP_PITCH    = 3'd3;
  localparam logic [2:0] OP_EXTEND   = 3'd4;
  localparam logic [2:0] OP_WINCH    = 3'd5;
  localparam logic [2:0] OP_RIGHT    = 3'd6;
  localparam logic [2:0] OP_LEFT     = 3'd7;

  state_e state_q;
  logic [2:0] op_q;
  logic [BAND_W-1:0] dead_band_q;
  logic [GEAR_W-1:0] gear_q;
  logic [2:0] btn_q;
  logic [LAMP_W-1:0] lamp_q;
  logic out_valid_q;
  logic [OUT_W-1:0] out_q;
  logic [IN_W-1:0] frame_q;
  logic neg_q;
  logic sat_q;
  logic [STICK_W-1:0] res_q [8];

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [STICK_W-1:0] stick;
  logic [STICK_W:0] v9;
  logic [STICK_W-1:0] mag;
  logic [STICK_W-1:0] diff;
  logic [14:0] dz_num;
  logic [9:0] x10, y10, mix10, left10, right10;
  logic [8:0] mix_mag, l_mag, r_mag, m_val;
  logic [14:0] mix127;
  logic is_track;
  logic start_neg;
  logic start_sat;
  logic [NUM_W-1:0] q;
  logic [8:0] neg_lim;
  logic [8:0] neg_res;
  logic [STICK_W-1:0] capt;
  logic [2:0] now_btn, rise;
  logic [GEAR_W-1:0] gear_mid, gear_next;
  logic [LAMP_W-1:0] lamp_next;

  tdsm_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign is_track = (op_q == OP_RIGHT) || (op_q == OP_LEFT);

  always_comb begin
    unique case (op_q)
      OP_STEER:    stick = frame_q[7:0];
      OP_THROTTLE: stick = frame_q[15:8];
      OP_TURRET:   stick = frame_q[23:16];
      OP_PITCH:    stick = frame_q[31:24];
      OP_EXTEND:   stick = frame_q[39:32];
      OP_WINCH:    stick = frame_q[47:40];
      default:     stick = '0;
    endcase
  end

  // deadzone operands
  always_comb begin
    v9     = {stick[STICK_W-1], stick};
    mag    = stick[STICK_W-1] ? STICK_W'(-v9) : stick;
    diff   = mag - STICK_W'(dead_band_q);
    dz_num = {diff, 7'b0} - 15'(diff);
  end

  // track operands
  always_comb begin
    x10     = {{2{res_q[OP_STEER][STICK_W-1]}}, res_q[OP_STEER]};
    y10     = {{2{res_q[OP_THROTTLE][STICK_W-1]}}, res_q[OP_THROTTLE]};
    left10  = y10 + x10;
    right10 = y10 - x10;
    l_mag   = left10[9] ? 9'(-left10) : left10[8:0];
    r_mag   = right10[9] ? 9'(-right10) : right10[8:0];
    m_val   = (l_mag > r_mag) ? l_mag : r_mag;
    if (m_val < 9'd127) begin
      m_val = 9'd127;
    end
    mix10   = (op_q == OP_RIGHT) ? right10 : left10;
    mix_mag = mix10[9] ? 9'(-mix10) : mix10[8:0];
    mix127  = {mix_mag[7:0], 7'b0} - 15'(mix_mag);
  end

  always_comb begin
    div_req.start = (state_q == ST_LOAD);
    start_sat     = 1'b0;
    if (is_track) begin
      div_req.num = NUM_W'(mix127) * NUM_W'(gear_q);
      div_req.den = DEN_W'(m_val) * DEN_W'(GEAR_COUNT);
      start_neg   = mix10[9];
    end else if (dead_band_q == BAND_FULL) begin
      div_req.num = '0;
      div_req.den = DEN_W'(1);
      start_neg   = 1'b0;
      start_sat   = (stick == {1'b1, {(STICK_W-1){1'b0}}});
    end else if (mag > STICK_W'(dead_band_q)) begin
      div_req.num = NUM_W'(dz_num);
      div_req.den = DEN_W'(BAND_FULL - dead_band_q);
      start_neg   = stick[STICK_W-1];
    end else begin
      div_req.num = '0;
      div_req.den = DEN_W'(1);
      start_neg   = 1'b0;
    end
  end

  // sign and saturation of a finished quotient
  always_comb begin
    q       = div_rsp.quot;
    neg_lim = is_track ? 9'd127 : 9'd128;
    neg_res = 9'(-{1'b0, q[7:0]});
    if (sat_q) begin
      capt = {1'b1, {(STICK_W-1){1'b0}}};
    end else if (neg_q) begin
      capt = (q > NUM_W'(neg_lim)) ? STICK_W'(-neg_lim) : neg_res[7:0];
    end else begin
      capt = (q > NUM_W'(127)) ? STICK_W'(127) : q[7:0];
    end
  end

  // button edges, gear and lamp
  always_comb begin
    now_btn  = frame_q[50:48];
    rise     = now_btn & ~btn_q;
    gear_mid = gear_q;
    if (rise[0] && (gear_q > GEAR_LOW)) begin
      gear_mid = gear_q - GEAR_W'(1);
    end
    gear_next = gear_mid;
    if (rise[1] && (gear_mid < GEAR_TOP)) begin
      gear_next = gear_mid + GEAR_W'(1);
    end
    lamp_next = lamp_q;
    if (rise[2]) begin
      lamp_next = (lamp_q != '0) ? '0 : LAMP_ON;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_STEER;
      dead_band_q <= DEAD_BAND_RST;
      gear_q      <= GEAR_TOP;
      btn_q       <= '0;
      lamp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dead_band_q <= cfg_wdata_i;
      end
      if (out_valid_q && m_axis_tready && (state_q != ST_POST)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op_q    <= OP_STEER;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_rsp.done) begin
            if (op_q == OP_LEFT) begin
              state_q <= ST_POST;
            end else begin
              op_q    <= op_q + 3'd1;
              state_q <= ST_LOAD;
            end
          end
        end
        ST_POST: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            gear_q      <= gear_next;
            lamp_q      <= lamp_next;
            btn_q       <= now_btn;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      frame_q <= s_axis_tdata;
    end
    if (state_q == ST_LOAD) begin
      neg_q <= start_neg;
      sat_q <= start_sat;
    end
    if ((state_q == ST_WAIT) && div_rsp.done) begin
      res_q[op_q] <= capt;
    end
    if ((state_q == ST_POST) && (!out_valid_q || m_axis_tready)) begin
      out_q <= {6'b0, gear_next, lamp_next,
                res_q[OP_WINCH], res_q[OP_EXTEND], res_q[OP_PITCH],
                res_q[OP_TURRET], res_q[OP_LEFT], res_q[OP_RIGHT]};
    end
  end

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for tank_drive_stick_mixer_unit, deadzone, track mix,
// gear and lamp state predicted per request and compared against every result
// depends on tdsm_pkg and the tank_drive_stick_mixer_unit rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tdsm_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_FRAMES = 150;

  // packed from msb down to match m_axis_tdata[57:0]
  typedef struct packed {
    logic [GEAR_W-1:0]  gear;
    logic [LAMP_W-1:0]  lamp;
    logic [STICK_W-1:0] winch;
    logic [STICK_W-1:0] extend;
    logic [STICK_W-1:0] pitch;
    logic [STICK_W-1:0] turret;
    logic [STICK_W-1:0] left;
    logic [STICK_W-1:0] right;
  } mix_result_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [BAND_W-1:0]   cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;

  // predicted block state
  int          band_q    = int'(DEAD_BAND_RST);
  int          gear_q    = int'(GEAR_TOP);
  int          lamp_q    = 0;
  logic [2:0]  buttons_q = '0;

  mix_result_t pending_mixes[$];
  int          fail_count = 0;
  int          stall_left = 0;
  bit          tx_steady  = 1'b0;
  bit          rx_steady  = 1'b0;

  tank_drive_stick_mixer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic int dead_zone(int v);
    int q;
    q = 0;
    if (band_q >= int'(BAND_FULL)) return (v == -128) ? -128 : 0;
    if (v > band_q) q = (v - band_q) * 127 / (127 - band_q);
    else if (v < -band_q) q = (v + band_q) * 127 / (127 - band_q);
    if (q < -128) q = -128;
    if (q > 127) q = 127;
    return q;
  endfunction

  function automatic void mix_frame(logic [7:0] st, th, tu, pi, ex, wi, logic [2:0] btn);
    int          x, y, left, right, mag, amag, den, rt, lt;
    logic [2:0]  rise;
    mix_result_t r;
    x     = dead_zone($signed(st));
    y     = dead_zone($signed(th));
    left  = y + x;
    right = y - x;
    mag   = (left < 0) ? -left : left;
    amag  = (right < 0) ? -right : right;
    if (amag > mag) mag = amag;
    if (mag < 127) mag = 127;
    den = mag * int'(GEAR_COUNT);
    rt  = right * 127 * gear_q / den;
    lt  = left * 127 * gear_q / den;
    if (rt > 127) rt = 127;
    if (rt < -127) rt = -127;
    if (lt > 127) lt = 127;
    if (lt < -127) lt = -127;
    // gear held before this request feeds the tracks, then buttons apply
    rise = btn & ~buttons_q;
    if (rise[0] && gear_q > int'(GEAR_LOW)) gear_q--;
    if (rise[1] && gear_q < int'(GEAR_TOP)) gear_q++;
    if (rise[2]) lamp_q = (lamp_q != 0) ? 0 : int'(LAMP_ON);
    buttons_q = btn;
    r.right  = 8'(rt);
    r.left   = 8'(lt);
    r.turret = 8'(dead_zone($signed(tu)));
    r.pitch  = 8'(dead_zone($signed(pi)));
    r.extend = 8'(dead_zone($signed(ex)));
    r.winch  = 8'(dead_zone($signed(wi)));
    r.lamp   = LAMP_W'(lamp_q);
    r.gear   = GEAR_W'(gear_q);
    pending_mixes.push_back(r);
  endfunction

  function automatic logic [7:0] pick_stick();
    int   r;
    int   v;
    r = $urandom_range(0, 19);
    if (r < 13) return 8'($urandom_range(0, 255));
    if (r < 16) begin
      case ($urandom_range(0, 5))
        0: return 8'h80;
        1: return 8'h81;
        2: return 8'h7f;
        3: return 8'h00;
        4: return 8'hff;
        default: return 8'h01;
      endcase
    end
    v = band_q + $urandom_range(0, 1);
    if ($urandom_range(0, 1) == 1) v = -v;
    return 8'(v);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_frame(input logic [7:0] st, th, tu, pi, ex, wi, input logic [2:0] btn);
    int gap;
    gap = (!tx_steady && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, btn, wi, ex, pi, tu, th, st};
    do @(posedge clk_i); while (!s_axis_tready);
    mix_frame(st, th, tu, pi, ex, wi, btn);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_mixes.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_dead_band(input int value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= BAND_W'(value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    band_q = value;
  endtask

  task automatic test_stick_extremes();
    send_frame(8'h7f, 8'h7f, 8'h80, 8'h7f, 8'h00, 8'hff, 3'b000);
    send_frame(8'h80, 8'h80, 8'h7f, 8'h80, 8'h0a, 8'hf6, 3'b000);
    send_frame(8'h7f, 8'h80, 8'h0b, 8'hf5, 8'h01, 8'h81, 3'b000);
    send_frame(8'h80, 8'h7f, 8'h0c, 8'hf4, 8'h7e, 8'h82, 3'b000);
    drain_results();
  endtask

  task automatic test_band_extremes();
    set_dead_band(0);
    send_frame(8'h7f, 8'h00, 8'h80, 8'h7f, 8'hff, 8'h01, 3'b000);
    set_dead_band(int'(BAND_FULL));
    send_frame(8'h80, 8'h7f, 8'h80, 8'h7f, 8'h81, 8'h7e, 3'b000);
    send_frame(8'h00, 8'hff, 8'h01, 8'h80, 8'h80, 8'h00, 3'b000);
    // negative overshoot saturates
    set_dead_band(126);
    send_frame(8'h80, 8'h80, 8'h80, 8'h7f, 8'h7e, 8'h81, 3'b000);
    set_dead_band(1);
    send_frame(8'h80, 8'h02, 8'hfe, 8'h01, 8'hff, 8'h7f, 3'b000);
    set_dead_band(int'(DEAD_BAND_RST));
  endtask

  task automatic test_gear_buttons();
    logic [2:0] seq [15] = '{3'b001, 3'b000, 3'b001, 3'b000, 3'b001, 3'b000, 3'b001, 3'b000,
                             3'b011, 3'b000, 3'b010, 3'b110, 3'b010, 3'b000, 3'b111};
    foreach (seq[k])
      send_frame(pick_stick(), pick_stick(), pick_stick(), pick_stick(), pick_stick(),
                 pick_stick(), seq[k]);
    drain_results();
  endtask

  task automatic test_random_frames();
    int         band;
    logic [2:0] btn;
    btn = '0;
    for (int p = 0; p < 8; p++) begin
      case (p)
        1: band = 0;
        3: band = int'(BAND_FULL);
        5: band = 126;
        default: band = $urandom_range(0, 127);
      endcase
      set_dead_band(band);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_FRAMES; i++) begin
        if (p == 2 && i == PHASE_FRAMES / 2) drain_results();
        for (int k = 0; k < 3; k++)
          if ($urandom_range(0, 9) < 3) btn[k] = ~btn[k];
        send_frame(pick_stick(), pick_stick(), pick_stick(), pick_stick(), pick_stick(),
                   pick_stick(), btn);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (rx_steady) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 9) < 6) begin
      m_axis_tready <= 1'b1;
    end else begin
      stall_left = gap_len();
      m_axis_tready <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_check
    mix_result_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = mix_result_t'(m_axis_tdata[57:0]);
      if (pending_mixes.size() == 0) begin
        $error("result with nothing pending: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_mixes.pop_front();
        check_field("right_track", $signed(want.right), $signed(got.right));
        check_field("left_track", $signed(want.left), $signed(got.left));
        check_field("turret_drive", $signed(want.turret), $signed(got.turret));
        check_field("pitch_drive", $signed(want.pitch), $signed(got.pitch));
        check_field("extend_drive", $signed(want.extend), $signed(got.extend));
        check_field("winch_drive", $signed(want.winch), $signed(got.winch));
        check_field("lamp_level", want.lamp, got.lamp);
        check_field("gear_now", want.gear, got.gear);
        check_field("pad", 0, m_axis_tdata[OUT_W-1:58]);
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("tank_drive_stick_mixer_unit verification failed");
    $finish;
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_stick_extremes();
    test_band_extremes();
    test_gear_buttons();
    test_random_frames();
    drain_results();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending_mixes.size() == 0) begin
      $display("tank_drive_stick_mixer_unit verification clean");
    end else begin
      $display("tank_drive_stick_mixer_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tdsm_pkg.sv
rtl/core/tdsm_divider.sv
rtl/core/tank_drive_stick_mixer_unit.sv
tb/testbench.sv
